// ===== hdl/cma_pkg.sv =====
// cma_pkg: shared constants and types for the centered moving average block
// no dependencies; used by cma_div and centered_moving_average
package cma_pkg;

  localparam int DEF_MAX_RADIUS  = 31;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int RADIUS_BITS     = 5;
  localparam int WIN_BITS        = 6;
  localparam int POS_BITS        = 7;
  localparam int POS_MAX         = 127;
  localparam int SUM_EXTRA_BITS  = 6;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_NEG,
    KIND_AVG
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PRIMARY,
    ST_PENDING
  } state_t;

endpackage

// ===== hdl/centered_moving_average.sv =====
// centered_moving_average: top level, request sequencing, sample ring and running sum
// depends on cma_pkg, cma_ram, cma_div
//
// usage
//   input channel in_valid/in_stall carries in_sample and in_end_of_stream; the
//   block takes one request at a time and holds in_stall high while it works
//   result channel out_valid/out_stall carries out_average (-1 where the window
//   does not fit) and out_run_last on the final result of each request
//   cfg_we/cfg_radius sets the radius k and restarts the stream; write only idle
// timing
//   a request that yields a mean is accepted, then runs through the bit-serial
//   divider, then loads the output register; -1 results leave one per cycle
//   after accept while out_stall is low
//   a request with no result goes back to idle from its accept cycle
// reset and stall
//   reset clears radius, stream position, running sum and output valid
//   the ring needs no clearing; a stream only reads entries it has written
//   the next request is taken while the last result still waits in the output
//   register; further results wait while out_stall is high
module centered_moving_average #(
  parameter int MAX_RADIUS  = cma_pkg::DEF_MAX_RADIUS,
  parameter int SAMPLE_BITS = cma_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cma_pkg::RADIUS_BITS-1:0]     cfg_radius,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [SAMPLE_BITS-1:0]              in_sample,
  input  logic                                in_end_of_stream,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS:0]         out_average,
  output logic                                out_run_last
);

  localparam int RB       = cma_pkg::RADIUS_BITS;
  localparam int WB       = cma_pkg::WIN_BITS;
  localparam int PB       = cma_pkg::POS_BITS;
  localparam int SUM_BITS = SAMPLE_BITS + cma_pkg::SUM_EXTRA_BITS;
  localparam int AVG_BITS = SAMPLE_BITS + 1;
  localparam int RING_AW  = $clog2(2 * MAX_RADIUS + 1);
  localparam int RING_DEPTH = 2 ** RING_AW;

  cma_pkg::state_t state_r, state_nxt;
  cma_pkg::kind_t  kind_r, kind_nxt, kind_in;

  logic [RB-1:0]          radius_r, radius_nxt;
  logic [RING_AW-1:0]     wp_r, wp_nxt;
  logic [PB-1:0]          pos_r, pos_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic                   eos_r, eos_nxt;
  logic [RB-1:0]          pend_r, pend_nxt;
  logic [RING_AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [AVG_BITS-1:0]    out_avg_r, out_avg_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [RB-1:0]          k;
  logic [WB-1:0]          two_k;
  logic [WB-1:0]          win;
  logic                   in_acc;
  logic                   out_free;
  logic [SUM_BITS-1:0]    sum_add;
  logic                   p_lt_k;
  logic                   p_lt_2k;
  logic [PB-1:0]          p_minus_k;
  logic [RB-1:0]          pending;
  logic                   ram_re;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_BITS-1:0]    quotient;

  assign k     = (radius_r > RB'(MAX_RADIUS)) ? RB'(MAX_RADIUS) : radius_r;
  assign two_k = {k, 1'b0};
  assign win   = {k, 1'b1};

  assign in_stall = (state_r != cma_pkg::ST_IDLE) || cfg_we;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign sum_add   = sum_r + SUM_BITS'(in_sample);
  assign p_lt_k    = pos_r < PB'(k);
  assign p_lt_2k   = pos_r < PB'(two_k);
  assign p_minus_k = pos_r - PB'(k);

  always_comb begin
    if (p_lt_k) begin
      kind_in = cma_pkg::KIND_NEG;
      pending = '0;
    end else if (p_lt_2k) begin
      kind_in = cma_pkg::KIND_NONE;
      pending = RB'(p_minus_k + 1'b1);
    end else begin
      kind_in = cma_pkg::KIND_AVG;
      pending = k;
    end
  end

  assign div_start = in_acc && (kind_in == cma_pkg::KIND_AVG);
  assign ram_re    = (state_r == cma_pkg::ST_DIV);

  cma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp_r),
    .wdata (in_sample),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  cma_div #(
    .SUM_BITS (SUM_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_add),
    .divisor  (win),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    radius_nxt    = radius_r;
    wp_nxt        = wp_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    eos_nxt       = eos_r;
    pend_nxt      = pend_r;
    rd_addr_nxt   = rd_addr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_avg_nxt   = out_avg_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      cma_pkg::ST_IDLE: begin
        if (cfg_we) begin
          radius_nxt = cfg_radius;
          wp_nxt     = '0;
          pos_nxt    = '0;
          sum_nxt    = '0;
        end else if (in_acc) begin
          kind_nxt    = kind_in;
          eos_nxt     = in_end_of_stream;
          pend_nxt    = in_end_of_stream ? pending : '0;
          rd_addr_nxt = wp_r - RING_AW'(two_k);
          if (in_end_of_stream) begin
            wp_nxt  = '0;
            pos_nxt = '0;
            sum_nxt = '0;
          end else begin
            wp_nxt  = wp_r + 1'b1;
            pos_nxt = (pos_r == PB'(cma_pkg::POS_MAX)) ? pos_r : pos_r + 1'b1;
            sum_nxt = sum_add;
          end
          unique case (kind_in)
            cma_pkg::KIND_AVG: state_nxt = cma_pkg::ST_DIV;
            cma_pkg::KIND_NEG: state_nxt = cma_pkg::ST_PRIMARY;
            default: state_nxt = in_end_of_stream ? cma_pkg::ST_PENDING : cma_pkg::ST_IDLE;
          endcase
        end
      end
      cma_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = cma_pkg::ST_PRIMARY;
        end
      end
      cma_pkg::ST_PRIMARY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (pend_r == '0);
          if (kind_r == cma_pkg::KIND_AVG) begin
            out_avg_nxt = quotient[AVG_BITS-1:0];
            if (!eos_r) begin
              sum_nxt = sum_r - SUM_BITS'(ram_rdata);
            end
          end else begin
            out_avg_nxt = '1;
          end
          state_nxt = (pend_r == '0) ? cma_pkg::ST_IDLE : cma_pkg::ST_PENDING;
        end
      end
      cma_pkg::ST_PENDING: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = '1;
          out_last_nxt  = (pend_r == RB'(1));
          pend_nxt      = pend_r - 1'b1;
          if (pend_r == RB'(1)) begin
            state_nxt = cma_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = cma_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= '0;
      wp_r        <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= cma_pkg::KIND_NONE;
      eos_r       <= 1'b0;
      pend_r      <= '0;
    end else begin
      radius_r    <= radius_nxt;
      wp_r        <= wp_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      eos_r       <= eos_nxt;
      pend_r      <= pend_nxt;
    end
    rd_addr_r  <= rd_addr_nxt;
    out_avg_r  <= out_avg_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_average  = out_avg_r;
  assign out_run_last = out_last_r;

endmodule

// ===== hdl/cma_ram.sv =====
// cma_ram: generic single write port, single read port RAM with registered read
// no dependencies
module cma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/cma_div.sv =====
// cma_div: restoring divider, one quotient bit per cycle, dividend shifted out msb first
// depends on cma_pkg (divisor width)
module cma_div #(
  parameter int SUM_BITS = 22
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [SUM_BITS-1:0]           dividend,
  input  logic [cma_pkg::WIN_BITS-1:0]  divisor,
  output logic                          done,
  output logic [SUM_BITS-1:0]           quotient
);

  localparam int CNT_BITS = $clog2(SUM_BITS);
  localparam int WB       = cma_pkg::WIN_BITS;

  logic                busy_r, busy_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [SUM_BITS-1:0] quo_r, quo_nxt;
  logic [WB-1:0]       rem_r, rem_nxt;
  logic [WB-1:0]       den_r, den_nxt;
  logic [WB:0]         trial;
  logic [WB:0]         diff;
  logic                ge;

  assign trial = {rem_r, quo_r[SUM_BITS-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign done  = busy_r && (cnt_r == '0);
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(SUM_BITS - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[WB-1:0] : trial[WB-1:0];
      quo_nxt  = {quo_r[SUM_BITS-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule
